// ===== design/cra_pkg.sv =====
//------------------------------------------------------------------------------
// Contiguous ring allocator package
// Shared widths, codes and state types of the ring allocator.
//------------------------------------------------------------------------------
package cra_pkg;

	localparam int OFFSET_BITS = 20;
	localparam int SIZE_W      = 21;
	localparam int LEN_W       = 20;
	localparam int ADDR_W      = 32;
	localparam int STATUS_W    = 3;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 21'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BUF_SIZE    = 1'b0,
		CFG_BUFFER_BASE = 1'b1
	} cfg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_BAD_LEN  = 3'd1,
		ST_NO_SPACE = 3'd2,
		ST_BAD_ADDR = 3'd3,
		ST_OVER     = 3'd4
	} status_t;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_DIV,
		S_FIN,
		S_DONE
	} state_t;

endpackage

// ===== design/cra_if.sv =====
//------------------------------------------------------------------------------
// Contiguous ring allocator channels
// Request, response and configuration write channels with valid and ready.
//------------------------------------------------------------------------------
interface cra_req_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [cra_pkg::LEN_W-1:0]   length;
	logic [cra_pkg::ADDR_W-1:0]  address;

	modport source (output valid, output op, output length, output address, input ready);
	modport sink   (input valid, input op, input length, input address, output ready);
endinterface

interface cra_rsp_if;
	logic                         valid;
	logic                         ready;
	logic                         ok;
	logic [cra_pkg::ADDR_W-1:0]   region_address;
	logic [cra_pkg::STATUS_W-1:0] status;

	modport source (output valid, output ok, output region_address, output status,
		input ready);
	modport sink   (input valid, input ok, input region_address, input status,
		output ready);
endinterface

interface cra_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [cra_pkg::CFG_IDX_W-1:0]  index;
	logic [cra_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/cra_rem_unit.sv =====
//------------------------------------------------------------------------------
// Ring allocator remainder unit
// Restoring remainder, one dividend bit per cycle, for the wrapped release.
//------------------------------------------------------------------------------
module cra_rem_unit #(
	parameter int DIVIDEND_W = 23,
	parameter int DIVISOR_W  = cra_pkg::SIZE_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output logic                  done,
	output logic [DIVISOR_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [DIVIDEND_W-1:0] div_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;

	assign trial = {rem_q, div_q[DIVIDEND_W-1]};
	assign diff  = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			div_q <= {div_q[DIVIDEND_W-2:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= diff[DIVISOR_W-1:0];
			end else begin
				rem_q <= trial[DIVISOR_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// ===== design/contiguous_ring_allocator_unit.sv =====
//------------------------------------------------------------------------------
// Contiguous ring allocator
// Hands out and takes back contiguous regions of a ring buffer in FIFO order.
//------------------------------------------------------------------------------
// One request is worked on at a time. An allocate, and a release while the ring
// is not wrapped, passes through the evaluate and done states before the next
// acceptance. A release while the ring is wrapped runs the remainder unit, one
// bit per cycle over the sum, which is two bits wider than the wider of an
// offset and the ring size, between the evaluate and finish states. The
// response sits in an output register, so the next request is accepted while
// it waits to be taken. Configuration writes are always ready.
module contiguous_ring_allocator_unit #(
	parameter int OFFSET_BITS = cra_pkg::OFFSET_BITS
) (
	input logic      clk,
	input logic      arst_n,
	cra_cfg_if.sink  cfg,
	cra_req_if.sink  req,
	cra_rsp_if.source rsp
);

	localparam int OFS_W  = OFFSET_BITS + 1;
	localparam int SIZE_W = cra_pkg::SIZE_W;
	localparam int ADDR_W = cra_pkg::ADDR_W;
	localparam int LEN_W  = cra_pkg::LEN_W;
	localparam int CW     = ((OFS_W > SIZE_W) ? OFS_W : SIZE_W) + 2;

	cra_pkg::state_t state_q, state_d;

	logic [SIZE_W-1:0] size_q;
	logic [ADDR_W-1:0] base_q;
	logic [OFS_W-1:0]  alloc_q, rel_q, pad_q;

	logic              op_q;
	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] addr_q;

	logic                 res_ok_q;
	logic [ADDR_W-1:0]    res_addr_q;
	cra_pkg::status_t     res_status_q;

	logic                 rsp_valid_q;
	logic                 rsp_ok_q;
	logic [ADDR_W-1:0]    rsp_addr_q;
	cra_pkg::status_t     rsp_status_q;

	logic [CW-1:0] a_x, r_x, p_x, n_x, z_x, start_x, sum0, sum, t_x;
	logic          nowrap, rel_zero, fit_tail, fit_head;
	logic [SIZE_W-1:0] rem_val;

	logic              ev_ok;
	logic [ADDR_W-1:0] ev_addr;
	cra_pkg::status_t  ev_status;
	logic              ev_div;
	logic              set_alloc, set_rel, set_pad;
	logic [OFS_W-1:0]  alloc_d, rel_d, pad_d;

	logic              rem_start, rem_done;
	logic              in_ready, commit_res, rsp_free, load_rsp;

	assign a_x      = CW'(alloc_q);
	assign r_x      = CW'(rel_q);
	assign p_x      = CW'(pad_q);
	assign n_x      = CW'(len_q);
	assign z_x      = CW'(size_q);
	assign t_x      = CW'(rem_val);
	assign nowrap   = (a_x >= r_x);
	assign rel_zero = (rel_q == '0);
	assign fit_tail = (z_x >= a_x + n_x + CW'(rel_zero));
	assign start_x  = nowrap ? '0 : a_x;
	assign fit_head = (r_x >= start_x + n_x + CW'(1));
	assign sum0     = r_x + n_x;
	assign sum      = (sum0 > z_x) ? sum0 + p_x : sum0;

	always_comb begin
		ev_ok     = 1'b0;
		ev_addr   = '0;
		ev_status = cra_pkg::ST_OK;
		ev_div    = 1'b0;
		set_alloc = 1'b0;
		set_rel   = 1'b0;
		set_pad   = 1'b0;
		alloc_d   = alloc_q;
		rel_d     = rel_q;
		pad_d     = pad_q;
		if (state_q == cra_pkg::S_FIN) begin
			if (t_x > a_x && t_x < r_x) begin
				ev_status = cra_pkg::ST_OVER;
			end else begin
				ev_ok   = 1'b1;
				set_rel = 1'b1;
				rel_d   = OFS_W'(t_x);
				if (t_x <= a_x) begin
					set_pad = 1'b1;
					pad_d   = '0;
				end
			end
		end else if (cra_pkg::op_t'(op_q) == cra_pkg::OP_ALLOC) begin
			if (len_q == '0 || n_x >= z_x) begin
				ev_status = cra_pkg::ST_BAD_LEN;
			end else if (nowrap && fit_tail) begin
				ev_ok     = 1'b1;
				ev_addr   = base_q + ADDR_W'(alloc_q);
				set_alloc = 1'b1;
				alloc_d   = OFS_W'(a_x + n_x);
			end else if (fit_head) begin
				ev_ok     = 1'b1;
				ev_addr   = base_q + ADDR_W'(start_x);
				set_alloc = 1'b1;
				alloc_d   = OFS_W'(start_x + n_x);
				set_pad   = 1'b1;
				pad_d     = nowrap ? OFS_W'(z_x - a_x - CW'(rel_zero)) : pad_q;
			end else begin
				ev_status = cra_pkg::ST_NO_SPACE;
			end
		end else begin
			if (n_x >= z_x) begin
				ev_status = cra_pkg::ST_BAD_LEN;
			end else if (addr_q != base_q + ADDR_W'(rel_q) && addr_q != base_q) begin
				ev_status = cra_pkg::ST_BAD_ADDR;
			end else if (nowrap) begin
				if (a_x < sum0) begin
					ev_status = cra_pkg::ST_OVER;
				end else begin
					ev_ok   = 1'b1;
					set_rel = 1'b1;
					rel_d   = OFS_W'(sum0);
				end
			end else begin
				ev_div = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cra_pkg::S_IDLE: begin
				if (req.valid) state_d = cra_pkg::S_EVAL;
			end
			cra_pkg::S_EVAL: begin
				state_d = ev_div ? cra_pkg::S_DIV : cra_pkg::S_DONE;
			end
			cra_pkg::S_DIV: begin
				if (rem_done) state_d = cra_pkg::S_FIN;
			end
			cra_pkg::S_FIN: begin
				state_d = cra_pkg::S_DONE;
			end
			cra_pkg::S_DONE: begin
				if (rsp_free) state_d = cra_pkg::S_IDLE;
			end
			default: begin
				state_d = cra_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready   = (state_q == cra_pkg::S_IDLE);
		rem_start  = (state_q == cra_pkg::S_EVAL) && ev_div;
		commit_res = ((state_q == cra_pkg::S_EVAL) && !ev_div) ||
			(state_q == cra_pkg::S_FIN);
		load_rsp   = (state_q == cra_pkg::S_DONE) && rsp_free;
	end

	assign rsp_free = !rsp_valid_q || rsp.ready;

	cra_rem_unit #(
		.DIVIDEND_W (CW),
		.DIVISOR_W  (SIZE_W)
	) u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (rem_start),
		.dividend  (sum),
		.divisor   (size_q),
		.done      (rem_done),
		.remainder (rem_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= cra_pkg::S_IDLE;
			size_q      <= cra_pkg::SIZE_RESET;
			base_q      <= '0;
			alloc_q     <= '0;
			rel_q       <= '0;
			pad_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				unique case (cra_pkg::cfg_idx_t'(cfg.index))
					cra_pkg::CFG_BUF_SIZE:    size_q <= cfg.data[SIZE_W-1:0];
					cra_pkg::CFG_BUFFER_BASE: base_q <= cfg.data[ADDR_W-1:0];
				endcase
			end
			if (commit_res) begin
				if (set_alloc) alloc_q <= alloc_d;
				if (set_rel)   rel_q   <= rel_d;
				if (set_pad)   pad_q   <= pad_d;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && req.valid) begin
			op_q   <= req.op;
			len_q  <= req.length;
			addr_q <= req.address;
		end
		if (commit_res) begin
			res_ok_q     <= ev_ok;
			res_addr_q   <= ev_addr;
			res_status_q <= ev_status;
		end
		if (load_rsp) begin
			rsp_ok_q     <= res_ok_q;
			rsp_addr_q   <= res_addr_q;
			rsp_status_q <= res_status_q;
		end
	end

	assign cfg.ready          = 1'b1;
	assign req.ready          = in_ready;
	assign rsp.valid          = rsp_valid_q;
	assign rsp.ok             = rsp_ok_q;
	assign rsp.region_address = rsp_addr_q;
	assign rsp.status         = rsp_status_q;

endmodule

// ===== design/cra_checker.sv =====
//------------------------------------------------------------------------------
// Contiguous ring allocator checker
// Port-level assertions on the ring allocator, bound to the top level.
//------------------------------------------------------------------------------
module cra_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic                         rsp_ok,
	input logic [cra_pkg::ADDR_W-1:0]   rsp_region_address,
	input logic [cra_pkg::STATUS_W-1:0] rsp_status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
		else $error("Response dropped or changed while stalled.");

	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_ok == (rsp_status == cra_pkg::ST_OK)))
		else $error("Success flag disagrees with status.");

	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_region_address == '0)
		else $error("Failed request returned a nonzero address.");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("Ready right after a request was accepted.");

endmodule

bind contiguous_ring_allocator_unit cra_checker u_cra_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_ok             (rsp.ok),
	.rsp_region_address (rsp.region_address),
	.rsp_status         (rsp.status)
);
